/* sv/msclip_pkg.sv */
// ----------------------------------------------------------------------------
// msclip_pkg
// Shared types and constants for the midpoint subdivision line clipper:
// controller states, command and status groups, register indexes and the
// reset values of the window registers.
// ----------------------------------------------------------------------------
package msclip_pkg;

	localparam int EPS_W     = 34;
	localparam int CFG_W     = 34;
	localparam int CFG_IDX_W = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_XMIN = 3'd0;
	localparam cfg_idx_t REG_XMAX = 3'd1;
	localparam cfg_idx_t REG_YMIN = 3'd2;
	localparam cfg_idx_t REG_YMAX = 3'd3;
	localparam cfg_idx_t REG_EPS  = 3'd4;

	// window reset values, truncated to the coordinate width where used
	localparam logic [31:0] XMIN_RST = 32'd0;
	localparam logic [31:0] XMAX_RST = 32'd11360;
	localparam logic [31:0] YMIN_RST = 32'd0;
	localparam logic [31:0] YMAX_RST = 32'd11696;
	localparam logic [EPS_W-1:0] EPS_RST = 34'd512;
	localparam logic [EPS_W-1:0] EPS_MIN = 34'd2;

	localparam logic [1:0] PASS_FIRST = 2'd1;
	localparam logic [1:0] PASS_OVER  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LEN,
		ST_STEP,
		ST_SWAP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;      // take a new segment
		logic save;      // remember the first endpoint of the pass
		logic step;      // one halving of the segment
		logic finish;    // end of pass: near <= far, far <= saved
		logic out_load;  // fill the output register
		logic out_vis;   // visible flag for the output register
	} dp_cmd_t;

	typedef struct packed {
		logic near_in;   // near endpoint has a zero outcode
		logic far_in;    // far endpoint has a zero outcode
		logic share;     // outcodes of near and far share a bit
		logic len_over;  // squared length above threshold
	} dp_stat_t;

endpackage

/* sv/msclip_ctrl.sv */
// ----------------------------------------------------------------------------
// msclip_ctrl
// Controller for the clipper: sequences outcode checks, halving passes and
// the endpoint swap, counts passes and owns the output request valid.
// ----------------------------------------------------------------------------
module msclip_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  msclip_pkg::dp_stat_t stat,
	output msclip_pkg::dp_cmd_t  cmd
);
	import msclip_pkg::*;

	state_t     state_q;
	state_t     state_nxt;
	logic [1:0] pass_q;
	logic       vis_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid)
					state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if ((stat.near_in && stat.far_in) || stat.share || pass_q == PASS_OVER)
					state_nxt = ST_DONE;
				else if (!stat.far_in)
					state_nxt = ST_LEN;
				else
					state_nxt = ST_SWAP;
			end
			ST_LEN:  state_nxt = ST_STEP;
			ST_STEP: begin
				if (stat.len_over)
					state_nxt = ST_LEN;
				else
					state_nxt = ST_SWAP;
			end
			ST_SWAP: state_nxt = ST_CHECK;
			ST_DONE: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:  cmd.load = s_axis_tvalid;
			ST_CHECK: cmd.save = 1'b1;
			ST_LEN:   ;
			ST_STEP:  cmd.step = stat.len_over;
			ST_SWAP:  cmd.finish = 1'b1;
			ST_DONE: begin
				cmd.out_load = out_free;
				cmd.out_vis  = vis_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= PASS_FIRST;
			vis_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load)
				pass_q <= PASS_FIRST;
			else if (cmd.finish)
				pass_q <= pass_q + 2'd1;
			// both inside wins, a shared bit rejects, otherwise the pass limit accepts
			if (state_q == ST_CHECK)
				vis_q <= (stat.near_in && stat.far_in) || !stat.share;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* sv/msclip_dp.sv */
// ----------------------------------------------------------------------------
// msclip_dp
// Datapath for the clipper: window and threshold registers, endpoint
// registers, outcodes, midpoint, registered squared length and the output
// register.
// ----------------------------------------------------------------------------
module msclip_dp #(
	parameter int COORD_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  msclip_pkg::cfg_idx_t               cfg_index,
	input  logic [msclip_pkg::CFG_W-1:0]       cfg_data,
	input  logic signed [COORD_BITS-1:0]       start_x,
	input  logic signed [COORD_BITS-1:0]       start_y,
	input  logic signed [COORD_BITS-1:0]       end_x,
	input  logic signed [COORD_BITS-1:0]       end_y,
	input  msclip_pkg::dp_cmd_t                cmd,
	output msclip_pkg::dp_stat_t               stat,
	output logic                               visible,
	output logic signed [COORD_BITS-1:0]       out_ax,
	output logic signed [COORD_BITS-1:0]       out_ay,
	output logic signed [COORD_BITS-1:0]       out_bx,
	output logic signed [COORD_BITS-1:0]       out_by
);
	import msclip_pkg::*;

	localparam int CW    = COORD_BITS;
	localparam int DW    = COORD_BITS + 1;
	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int SUM_W = SQ_W + 1;
	localparam int CMP_W = (SUM_W > EPS_W) ? SUM_W : EPS_W;

	logic signed [CW-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
	logic [EPS_W-1:0]     eps_q;

	logic signed [CW-1:0] near_x_q, near_y_q, far_x_q, far_y_q, sav_x_q, sav_y_q;
	logic [SQ_W-1:0]      sqx_q, sqy_q;

	logic                 vis_q;
	logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;

	logic [3:0]           code_near, code_far, code_mid;
	logic signed [DW-1:0] sum_x, sum_y, dif_x, dif_y;
	logic signed [CW-1:0] mid_x, mid_y;
	logic [CW-1:0]        adx, ady;
	logic [SUM_W-1:0]     len_sq;
	logic [EPS_W-1:0]     thr;

	function automatic logic [3:0] outcode(
		input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y,
		input logic signed [CW-1:0] x_lo,
		input logic signed [CW-1:0] x_hi,
		input logic signed [CW-1:0] y_lo,
		input logic signed [CW-1:0] y_hi
	);
		logic [3:0] c;
		c[3] = (x < x_lo);
		c[2] = (x > x_hi);
		c[1] = (y < y_lo);
		c[0] = (y > y_hi);
		return c;
	endfunction

	assign code_near = outcode(near_x_q, near_y_q, xmin_q, xmax_q, ymin_q, ymax_q);
	assign code_far  = outcode(far_x_q, far_y_q, xmin_q, xmax_q, ymin_q, ymax_q);

	// midpoint rounded toward minus infinity
	assign sum_x = {near_x_q[CW-1], near_x_q} + {far_x_q[CW-1], far_x_q};
	assign sum_y = {near_y_q[CW-1], near_y_q} + {far_y_q[CW-1], far_y_q};
	assign mid_x = sum_x[DW-1:1];
	assign mid_y = sum_y[DW-1:1];
	assign code_mid = outcode(mid_x, mid_y, xmin_q, xmax_q, ymin_q, ymax_q);

	assign dif_x = {near_x_q[CW-1], near_x_q} - {far_x_q[CW-1], far_x_q};
	assign dif_y = {near_y_q[CW-1], near_y_q} - {far_y_q[CW-1], far_y_q};
	assign adx   = dif_x[DW-1] ? CW'(-dif_x) : CW'(dif_x);
	assign ady   = dif_y[DW-1] ? CW'(-dif_y) : CW'(dif_y);

	assign len_sq = SUM_W'(sqx_q) + SUM_W'(sqy_q);
	assign thr    = (eps_q < EPS_MIN) ? EPS_MIN : eps_q;

	assign stat.near_in  = (code_near == 4'd0);
	assign stat.far_in   = (code_far == 4'd0);
	assign stat.share    = |(code_near & code_far);
	assign stat.len_over = CMP_W'(len_sq) > CMP_W'(thr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xmin_q <= XMIN_RST[CW-1:0];
			xmax_q <= XMAX_RST[CW-1:0];
			ymin_q <= YMIN_RST[CW-1:0];
			ymax_q <= YMAX_RST[CW-1:0];
			eps_q  <= EPS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_XMIN: xmin_q <= cfg_data[CW-1:0];
				REG_XMAX: xmax_q <= cfg_data[CW-1:0];
				REG_YMIN: ymin_q <= cfg_data[CW-1:0];
				REG_YMAX: ymax_q <= cfg_data[CW-1:0];
				REG_EPS:  eps_q  <= cfg_data[EPS_W-1:0];
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sqx_q <= adx * adx;
		sqy_q <= ady * ady;
		if (cmd.save) begin
			sav_x_q <= near_x_q;
			sav_y_q <= near_y_q;
		end
		if (cmd.load) begin
			near_x_q <= start_x;
			near_y_q <= start_y;
			far_x_q  <= end_x;
			far_y_q  <= end_y;
		end else if (cmd.step) begin
			// keep the half that still reaches outside through the far code
			if (|(code_mid & code_far)) begin
				far_x_q <= mid_x;
				far_y_q <= mid_y;
			end else begin
				near_x_q <= mid_x;
				near_y_q <= mid_y;
			end
		end else if (cmd.finish) begin
			near_x_q <= far_x_q;
			near_y_q <= far_y_q;
			far_x_q  <= sav_x_q;
			far_y_q  <= sav_y_q;
		end
		if (cmd.out_load) begin
			vis_q <= cmd.out_vis;
			ax_q  <= cmd.out_vis ? near_x_q : '0;
			ay_q  <= cmd.out_vis ? near_y_q : '0;
			bx_q  <= cmd.out_vis ? far_x_q  : '0;
			by_q  <= cmd.out_vis ? far_y_q  : '0;
		end
	end

	assign visible = vis_q;
	assign out_ax  = ax_q;
	assign out_ay  = ay_q;
	assign out_bx  = bx_q;
	assign out_by  = by_q;

endmodule

/* sv/midpoint_subdivision_line_clipper.sv */
// A segment accepted or rejected on its outcodes passes IDLE, CHECK and DONE
// before its result is registered; each clip pass (at most two) runs LEN and
// STEP once per halving and then SWAP before the next CHECK, or goes straight
// from CHECK to SWAP when the far endpoint is already inside.
// One segment at a time; the square-and-compare loop of the halving sets the rate.
// A new request is taken while the previous result waits in the output register.
// Reset clears the controller and loads the window and threshold defaults.
// ----------------------------------------------------------------------------
// midpoint_subdivision_line_clipper
// Clips one line segment per request against a configurable window by
// midpoint subdivision and returns the visible flag and final endpoints.
// ----------------------------------------------------------------------------
module midpoint_subdivision_line_clipper #(
	parameter int COORD_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_wr_en,
	input  msclip_pkg::cfg_idx_t                      cfg_index,
	input  logic [msclip_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	// start_x, start_y, end_x, end_y
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	// out_ax, out_ay, out_bx, out_by
	output logic [((4*COORD_BITS+7)/8)*8-1:0]         m_axis_tdata,
	// visible
	output logic [0:0]                                m_axis_tuser
);
	import msclip_pkg::*;

	localparam int DATA_W = ((4*COORD_BITS+7)/8)*8;

	dp_cmd_t                      cmd;
	dp_stat_t                     stat;
	logic                         visible;
	logic signed [COORD_BITS-1:0] out_ax, out_ay, out_bx, out_by;

	msclip_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	msclip_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start_x   (s_axis_tdata[0*COORD_BITS +: COORD_BITS]),
		.start_y   (s_axis_tdata[1*COORD_BITS +: COORD_BITS]),
		.end_x     (s_axis_tdata[2*COORD_BITS +: COORD_BITS]),
		.end_y     (s_axis_tdata[3*COORD_BITS +: COORD_BITS]),
		.cmd       (cmd),
		.stat      (stat),
		.visible   (visible),
		.out_ax    (out_ax),
		.out_ay    (out_ay),
		.out_bx    (out_bx),
		.out_by    (out_by)
	);

	assign m_axis_tdata = DATA_W'({out_by, out_bx, out_ay, out_ax});
	assign m_axis_tuser = visible;

endmodule
